[design/websocket_frame_deframer_assert.svh]
// Assertion macros for the WebSocket deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define WSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WSFD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WSFD_ASSERT(label, prop, msg)
`define WSFD_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[design/wsfd_pkg.sv]
// Shared types and constants for the WebSocket deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned OpcodeW  = 4;
  localparam int unsigned LenW     = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned TuserW   = 8;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  typedef struct packed {
    logic               emit;
    logic [ByteW-1:0]   payload;
    logic               fin;
    logic [OpcodeW-1:0] opcode;
    logic               last;
    logic               empty;
  } result_t;

endpackage

`default_nettype wire

[design/websocket_frame_deframer.sv]
// Input bytes are held in the input register and parsed into the result register.
// Throughput: one byte per cycle without stall; input and result registers are
//   separated, so a byte is taken while a finished result waits for m_axis_tready.
// Header bytes produce no result; a zero-length frame yields one empty marker.
// Reset: rst_ni clears all parse state and both valid flags asynchronously.
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [wsfd_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [wsfd_pkg::ByteW-1:0]           m_axis_tdata,   // [7:0] payload_byte
  output logic                                 m_axis_tlast,   // frame_last
  // [0] frame_fin, [4:1] frame_opcode, [5] frame_empty, [7:6] zero
  output logic [wsfd_pkg::TuserW-1:0]          m_axis_tuser
);

  logic                          in_valid_q;
  logic [wsfd_pkg::ByteW-1:0]    in_byte_q;
  logic                          advance;
  wsfd_pkg::result_t             res;

  logic                          out_valid_q;
  logic [wsfd_pkg::ByteW-1:0]    out_byte_q;
  logic                          out_fin_q;
  logic [wsfd_pkg::OpcodeW-1:0]  out_opcode_q;
  logic                          out_last_q;
  logic                          out_empty_q;

  // Process the held byte once the result register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wsfd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_byte_q   <= res.payload;
      out_fin_q    <= res.fin;
      out_opcode_q <= res.opcode;
      out_last_q   <= res.last;
      out_empty_q  <= res.empty;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {2'b00, out_empty_q, out_opcode_q, out_fin_q};

  `WSFD_ASSERT(a_empty_is_last,
    (m_axis_tvalid && m_axis_tuser[5]) |-> (m_axis_tlast && (m_axis_tdata == '0)),
    "empty marker without last flag or with nonzero data")
  `WSFD_ASSERT(a_in_hold,
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)),
    "held input byte lost or changed before processing")
  `WSFD_ASSERT_NEVER(a_no_overwrite,
    advance && out_valid_q && !m_axis_tready,
    "result register overwritten while stalled")

endmodule

`default_nettype wire

[design/wsfd_parse.sv]
// Frame header parser and payload unmasking for one byte per cycle while step_i is high.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parse (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             step_i,
  input  wire logic [wsfd_pkg::ByteW-1:0]       byte_i,
  output wsfd_pkg::result_t                     res_o
);

  wsfd_pkg::phase_e                 phase_q, phase_d;
  logic                             fin_q, fin_d;
  logic [wsfd_pkg::OpcodeW-1:0]     opcode_q, opcode_d;
  logic                             masked_q, masked_d;
  logic [wsfd_pkg::LenW-1:0]        remain_q, remain_d;
  logic [2:0]                       hcnt_q, hcnt_d;
  logic [wsfd_pkg::KeyW-1:0]        key_q, key_d;
  logic [1:0]                       kidx_q, kidx_d;

  logic [2:0]                       hcnt_inc;
  logic [wsfd_pkg::LenW-1:0]        remain_dec;
  logic [wsfd_pkg::ByteW-1:0]       key_byte;
  logic                             len_done;
  logic                             hdr_done;

  assign hcnt_inc   = hcnt_q + 3'd1;
  assign remain_dec = (remain_q != '0) ? remain_q - 64'd1 : '0;

  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    remain_d = remain_q;
    hcnt_d   = hcnt_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    len_done = 1'b0;
    hdr_done = 1'b0;
    res_o         = '0;
    res_o.fin     = fin_q;
    res_o.opcode  = opcode_q;

    case (phase_q)
      wsfd_pkg::PH_HDR1: begin
        masked_d = byte_i[7];
        key_d    = '0;
        kidx_d   = '0;
        hcnt_d   = '0;
        if (byte_i[6:0] == wsfd_pkg::LenCode16) begin
          remain_d = '0;
          phase_d  = wsfd_pkg::PH_LEN16;
        end else if (byte_i[6:0] == wsfd_pkg::LenCode64) begin
          remain_d = '0;
          phase_d  = wsfd_pkg::PH_LEN64;
        end else begin
          remain_d = {57'd0, byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      wsfd_pkg::PH_LEN16: begin
        remain_d = {48'd0, remain_q[7:0], byte_i};
        hcnt_d   = hcnt_inc;
        len_done = (hcnt_inc >= 3'd2);
      end
      wsfd_pkg::PH_LEN64: begin
        remain_d = {remain_q[55:0], byte_i};
        hcnt_d   = hcnt_inc;
        len_done = (hcnt_inc == 3'd0);
      end
      wsfd_pkg::PH_KEY: begin
        key_d    = {key_q[23:0], byte_i};
        hcnt_d   = hcnt_inc;
        hdr_done = (hcnt_inc >= 3'd4);
      end
      wsfd_pkg::PH_DATA: begin
        kidx_d        = kidx_q + 2'd1;
        remain_d      = remain_dec;
        res_o.emit    = 1'b1;
        res_o.payload = byte_i ^ key_byte;
        res_o.last    = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_d = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[3:0];
        phase_d  = wsfd_pkg::PH_HDR1;
      end
    endcase

    // Length known: fetch the key or finish the header.
    if (len_done) begin
      hcnt_d = '0;
      if (masked_d) begin
        phase_d = wsfd_pkg::PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: flag an empty frame or start the payload.
    if (hdr_done) begin
      hcnt_d = '0;
      kidx_d = '0;
      if (remain_d == '0) begin
        phase_d     = wsfd_pkg::PH_HDR0;
        res_o.emit  = 1'b1;
        res_o.last  = 1'b1;
        res_o.empty = 1'b1;
      end else begin
        phase_d = wsfd_pkg::PH_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_HDR0;
      fin_q    <= 1'b0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      remain_q <= '0;
      hcnt_q   <= '0;
      key_q    <= '0;
      kidx_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      remain_q <= remain_d;
      hcnt_q   <= hcnt_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
    end
  end

endmodule

`default_nettype wire
